// ----- rtl/bct_pkg.sv -----
// shared constants, types and codes for the binary contour tracer
// no dependencies; the engine, top and testbench refer to it by scoped names
package bct_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxPoints = 4096;

  localparam int unsigned PixCells = MaxWidth * MaxHeight;
  localparam int unsigned PixAw    = $clog2(PixCells);
  localparam int unsigned AreaW    = PixAw + 1;
  localparam int unsigned PtAw     = $clog2(MaxPoints);
  localparam int unsigned CntW     = 13;
  localparam int unsigned DimW     = 9;
  localparam int unsigned StepW    = AreaW + 2;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgW     = 13;

  localparam logic [PixW-1:0] BorderValue = 8'd255;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BEGIN = 2'd1,
    OP_FIND  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_THRESHOLD  = 2'd2,
    REG_MIN_REGION = 2'd3
  } reg_e;

  typedef struct packed {
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [AreaW-1:0] area;
    logic [AreaW-1:0] last_row;
    logic [PixW-1:0]  threshold;
    logic [CntW-1:0]  min_region;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic             scan_done;
    logic [CntW-1:0]  point_count;
    logic [PixAw-1:0] point_index;
    logic             overflow;
  } res_t;

endpackage

// ----- rtl/bct_ram.sv -----
// generic single-write, single-read synchronous ram, read data registered
// no dependencies
module bct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/bct_engine.sv -----
// sequencer for the tracer: image, visited and point memories with border
// paint, visited clear, raster scan and square tracing; uses bct_pkg, bct_ram
module bct_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bct_pkg::cfg_t           cfg_i,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  bct_pkg::op_e            req_op_i,
  input  logic [bct_pkg::PixAw-1:0] req_addr_i,
  input  logic [bct_pkg::PixW-1:0]  req_pixel_i,
  input  logic                    slot_free_i,
  output bct_pkg::res_t           res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BORDER,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_PR_RD,
    ST_PR_EV,
    ST_TEND,
    ST_FIN
  } state_e;

  localparam int unsigned PixAw = bct_pkg::PixAw;
  localparam int unsigned AreaW = bct_pkg::AreaW;
  localparam int unsigned StepW = bct_pkg::StepW;
  localparam int unsigned CntW  = bct_pkg::CntW;
  localparam int unsigned DimW  = bct_pkg::DimW;
  localparam int unsigned PtAw  = bct_pkg::PtAw;
  localparam int unsigned PixW  = bct_pkg::PixW;

  state_e            state_q, state_d;
  logic [PixAw-1:0]  pos_q, pos_d;
  logic [PixAw-1:0]  start_q, start_d;
  logic [PixAw-1:0]  cur_q, cur_d;
  logic [PixAw-1:0]  nbr_q, nbr_d;
  logic              oob_q, oob_d;
  logic [1:0]        dir_q, dir_d;
  logic              diag_q, diag_d;
  logic              init_q, init_d;
  logic              bg_q, bg_d;
  logic [StepW-1:0]  tlen_q, tlen_d;
  logic [StepW-1:0]  steps_q, steps_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   stored_q, stored_d;
  logic              found_q, found_d;
  logic              done_q, done_d;
  logic              psel_q, psel_d;
  logic              beg_q, beg_d;
  logic [PixAw-1:0]  clr_q, clr_d;
  logic [1:0]        bd_phase_q, bd_phase_d;
  logic [DimW-1:0]   bd_k_q, bd_k_d;
  logic [PixAw-1:0]  bd_addr_q, bd_addr_d;

  // memory ports
  logic              img_we, img_re;
  logic [PixAw-1:0]  img_waddr, img_raddr;
  logic [PixW-1:0]   img_wdata, img_rdata;
  logic              vis_we, vis_re, vis_wdata, vis_rdata;
  logic [PixAw-1:0]  vis_waddr, vis_raddr;
  logic              pt_we, pt_re;
  logic [PtAw-1:0]   pt_waddr, pt_raddr;
  logic [PixAw-1:0]  pt_wdata, pt_rdata;

  // neighbour address and scan advance
  logic signed [AreaW:0] wsig, off, nsum;
  logic              n_oob;
  logic [AreaW-1:0]  adv_nxt;
  logic              adv_done;
  logic [StepW-1:0]  limit;
  logic              fg, moved, stepped, accept;
  logic [PixAw-1:0]  newcur;
  logic [DimW-1:0]   bd_lim, bd_step;

  bct_ram #(.Width(PixW), .Depth(bct_pkg::PixCells)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_waddr), .wdata_i(img_wdata),
    .re_i(img_re), .raddr_i(img_raddr), .rdata_o(img_rdata)
  );

  bct_ram #(.Width(1), .Depth(bct_pkg::PixCells)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .re_i(vis_re), .raddr_i(vis_raddr), .rdata_o(vis_rdata)
  );

  bct_ram #(.Width(PixAw), .Depth(bct_pkg::MaxPoints)) u_pt (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .re_i(pt_re), .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );

  always_comb begin
    wsig = $signed({{(AreaW+1-DimW){1'b0}}, cfg_i.width});
    case ({diag_q, dir_q})
      3'b100:  off = -(AreaW+1)'(1) - wsig;
      3'b101:  off = (AreaW+1)'(1) - wsig;
      3'b110:  off = (AreaW+1)'(1) + wsig;
      3'b111:  off = wsig - (AreaW+1)'(1);
      3'b000:  off = -wsig;
      3'b001:  off = (AreaW+1)'(1);
      3'b010:  off = wsig;
      default: off = -(AreaW+1)'(1);
    endcase
    nsum  = $signed({2'b00, cur_q}) + off;
    n_oob = nsum[AreaW] || (nsum[AreaW-1:0] >= cfg_i.area);
  end

  assign adv_nxt  = {1'b0, pos_q} + AreaW'(1);
  assign adv_done = adv_nxt >= cfg_i.last_row;
  assign limit    = {cfg_i.area, 2'b00} + StepW'(4);
  assign accept   = (state_q == ST_IDLE) && req_valid_i && slot_free_i;
  assign bd_lim   = (bd_phase_q < 2'd2) ? cfg_i.width - DimW'(1) : cfg_i.height - DimW'(1);
  assign bd_step  = (bd_phase_q < 2'd2) ? DimW'(1) : cfg_i.width;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    start_d    = start_q;
    cur_d      = cur_q;
    nbr_d      = nbr_q;
    oob_d      = oob_q;
    dir_d      = dir_q;
    diag_d     = diag_q;
    init_d     = init_q;
    bg_d       = bg_q;
    tlen_d     = tlen_q;
    steps_d    = steps_q;
    ovf_d      = ovf_q;
    stored_d   = stored_q;
    found_d    = found_q;
    done_d     = done_q;
    psel_d     = psel_q;
    beg_d      = beg_q;
    clr_d      = clr_q;
    bd_phase_d = bd_phase_q;
    bd_k_d     = bd_k_q;
    bd_addr_d  = bd_addr_q;

    img_we    = 1'b0;
    img_waddr = req_addr_i;
    img_wdata = req_pixel_i;
    img_re    = 1'b0;
    img_raddr = pos_q;
    vis_we    = 1'b0;
    vis_waddr = pos_q;
    vis_wdata = 1'b1;
    vis_re    = 1'b0;
    vis_raddr = pos_q;
    pt_we     = 1'b0;
    pt_waddr  = tlen_q[PtAw-1:0];
    pt_wdata  = nbr_q;
    pt_re     = 1'b0;
    pt_raddr  = req_addr_i[PtAw-1:0];

    fg      = !oob_q && (img_rdata < cfg_i.threshold);
    moved   = 1'b0;
    stepped = 1'b0;
    newcur  = cur_q;

    req_ready_o = (state_q == ST_IDLE) && slot_free_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          done_d  = 1'b0;
          psel_d  = 1'b0;
          case (req_op_i)
            bct_pkg::OP_WRITE: begin
              img_we = ({1'b0, req_addr_i} < cfg_i.area);
            end
            bct_pkg::OP_BEGIN: begin
              bd_phase_d = 2'd0;
              bd_k_d     = '0;
              bd_addr_d  = '0;
              state_d    = ST_BORDER;
            end
            bct_pkg::OP_FIND: begin
              if ({1'b0, pos_q} >= cfg_i.last_row) begin
                pos_d   = cfg_i.last_row[PixAw-1:0];
                done_d  = 1'b1;
                state_d = ST_FIN;
              end else begin
                bg_d    = 1'b0;
                state_d = ST_SCAN_RD;
              end
            end
            bct_pkg::OP_READ: begin
              psel_d  = req_addr_i < PixAw'(stored_q);
              pt_re   = 1'b1;
              state_d = ST_FIN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_BORDER: begin
        img_we    = 1'b1;
        img_waddr = bd_addr_q;
        img_wdata = bct_pkg::BorderValue;
        if (bd_k_q == bd_lim) begin
          bd_k_d = '0;
          case (bd_phase_q)
            2'd0: begin
              bd_addr_d  = PixAw'(cfg_i.area - AreaW'(cfg_i.width));
              bd_phase_d = 2'd1;
            end
            2'd1: begin
              bd_addr_d  = '0;
              bd_phase_d = 2'd2;
            end
            2'd2: begin
              bd_addr_d  = PixAw'(cfg_i.width - DimW'(1));
              bd_phase_d = 2'd3;
            end
            default: begin
              clr_d   = '0;
              beg_d   = 1'b1;
              state_d = ST_CLEAR;
            end
          endcase
        end else begin
          bd_k_d    = bd_k_q + DimW'(1);
          bd_addr_d = bd_addr_q + PixAw'(bd_step);
        end
      end

      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        clr_d     = clr_q + PixAw'(1);
        if (clr_q == '1) begin
          if (beg_q) begin
            pos_d   = PixAw'(cfg_i.width) + PixAw'(1);
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN_RD: begin
        img_re  = 1'b1;
        vis_re  = 1'b1;
        state_d = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        if (bg_q && (img_rdata < cfg_i.threshold) && !vis_rdata) begin
          // unvisited rising edge: mark it and open a new trace
          vis_we   = 1'b1;
          pt_we    = 1'b1;
          pt_waddr = '0;
          pt_wdata = pos_q;
          start_d  = pos_q;
          cur_d    = pos_q;
          tlen_d   = StepW'(1);
          steps_d  = '0;
          ovf_d    = 1'b0;
          dir_d    = 2'd0;
          diag_d   = 1'b1;
          init_d   = 1'b1;
          state_d  = ST_PR_RD;
        end else begin
          bg_d = !(img_rdata < cfg_i.threshold);
          if (adv_done) begin
            pos_d   = cfg_i.last_row[PixAw-1:0];
            done_d  = 1'b1;
            state_d = ST_FIN;
          end else begin
            pos_d   = adv_nxt[PixAw-1:0];
            state_d = ST_SCAN_RD;
          end
        end
      end

      ST_PR_RD: begin
        img_re    = 1'b1;
        img_raddr = nsum[PixAw-1:0];
        nbr_d     = nsum[PixAw-1:0];
        oob_d     = n_oob;
        state_d   = ST_PR_EV;
      end

      ST_PR_EV: begin
        state_d = ST_PR_RD;
        if (init_q) begin
          // start direction: first of north, east, south with a foreground cell
          if (fg) begin
            init_d = 1'b0;
            diag_d = 1'b1;
          end else if (diag_q) begin
            diag_d = 1'b0;
          end else if (dir_q == 2'd2) begin
            dir_d  = 2'd3;
            init_d = 1'b0;
            diag_d = 1'b1;
          end else begin
            dir_d  = dir_q + 2'd1;
            diag_d = 1'b1;
          end
        end else begin
          if (diag_q) begin
            if (fg) begin
              moved   = 1'b1;
              stepped = 1'b1;
              newcur  = nbr_q;
              dir_d   = dir_q - 2'd1;
            end else begin
              diag_d = 1'b0;
            end
          end else begin
            stepped = 1'b1;
            if (fg) begin
              moved  = 1'b1;
              newcur = nbr_q;
            end else begin
              dir_d = dir_q + 2'd1;
            end
          end
          if (moved) begin
            if (tlen_q < StepW'(bct_pkg::MaxPoints)) begin
              pt_we = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            tlen_d = tlen_q + StepW'(1);
          end
          if (stepped) begin
            vis_we    = 1'b1;
            vis_waddr = newcur;
            cur_d     = newcur;
            steps_d   = steps_q + StepW'(1);
            diag_d    = 1'b1;
            if ((newcur == start_q) || (steps_q + StepW'(1) >= limit)) begin
              state_d = ST_TEND;
            end
          end
        end
      end

      ST_TEND: begin
        stored_d = (tlen_q >= StepW'(bct_pkg::MaxPoints)) ? CntW'(bct_pkg::MaxPoints)
                                                         : tlen_q[CntW-1:0];
        if (tlen_q > StepW'(cfg_i.min_region)) begin
          found_d = 1'b1;
          state_d = ST_FIN;
        end else begin
          bg_d = 1'b0;
          if (adv_done) begin
            pos_d   = cfg_i.last_row[PixAw-1:0];
            done_d  = 1'b1;
            state_d = ST_FIN;
          end else begin
            pos_d   = adv_nxt[PixAw-1:0];
            state_d = ST_SCAN_RD;
          end
        end
      end

      ST_FIN: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    res_o.valid       = (accept && (req_op_i == bct_pkg::OP_WRITE)) ||
                        ((state_q == ST_FIN) && slot_free_i);
    res_o.found       = (state_q == ST_FIN) && found_q;
    res_o.scan_done   = (state_q == ST_FIN) && done_q;
    res_o.point_count = stored_q;
    res_o.point_index = ((state_q == ST_FIN) && psel_q) ? pt_rdata : '0;
    res_o.overflow    = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      pos_q      <= '0;
      start_q    <= '0;
      cur_q      <= '0;
      nbr_q      <= '0;
      oob_q      <= 1'b0;
      dir_q      <= 2'd0;
      diag_q     <= 1'b0;
      init_q     <= 1'b0;
      bg_q       <= 1'b0;
      tlen_q     <= '0;
      steps_q    <= '0;
      ovf_q      <= 1'b0;
      stored_q   <= '0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      psel_q     <= 1'b0;
      beg_q      <= 1'b0;
      clr_q      <= '0;
      bd_phase_q <= 2'd0;
      bd_k_q     <= '0;
      bd_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      start_q    <= start_d;
      cur_q      <= cur_d;
      nbr_q      <= nbr_d;
      oob_q      <= oob_d;
      dir_q      <= dir_d;
      diag_q     <= diag_d;
      init_q     <= init_d;
      bg_q       <= bg_d;
      tlen_q     <= tlen_d;
      steps_q    <= steps_d;
      ovf_q      <= ovf_d;
      stored_q   <= stored_d;
      found_q    <= found_d;
      done_q     <= done_d;
      psel_q     <= psel_d;
      beg_q      <= beg_d;
      clr_q      <= clr_d;
      bd_phase_q <= bd_phase_d;
      bd_k_q     <= bd_k_d;
      bd_addr_q  <= bd_addr_d;
    end
  end

  a_tlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= steps_q + StepW'(1))
    else $error("trace length ran ahead of step count");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CntW'(bct_pkg::MaxPoints))
    else $error("stored point count beyond point store");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && ovf_q) |-> stored_q == CntW'(bct_pkg::MaxPoints))
    else $error("overflow flagged with point store not full");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> slot_free_i)
    else $error("result beat offered with output slot busy");

  a_cur_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PR_RD) |-> ({1'b0, cur_q} < cfg_i.area))
    else $error("trace position left the image");

endmodule

// ----- rtl/binary_contour_tracer_top.sv -----
// Binary contour tracer. Operation write stores one pixel in the cycle it is accepted,
// so pixel loads stream at one beat per cycle while the output register is free; read
// returns a stored point from the registered point memory. Begin paints the border and
// then clears the visited map, one entry a cycle; the same clearing pass runs after reset,
// during which no beat is taken. Find spends a read state and an evaluate state per pixel
// scanned and per neighbour probe while tracing (one or two probes per trace step, six at
// most to pick the start direction), as the image memory has a single read port.
// Results leave through an output register, one beat per operation.
// uses bct_pkg and bct_engine
module binary_contour_tracer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [bct_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [bct_pkg::PixAw-1:0]   address_i,
  input  logic [bct_pkg::PixW-1:0]    pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic                        scan_done_o,
  output logic [bct_pkg::CntW-1:0]    point_count_o,
  output logic [bct_pkg::PixAw-1:0]   point_index_o,
  output logic                        overflow_o
);

  localparam int unsigned DimW  = bct_pkg::DimW;
  localparam int unsigned AreaW = bct_pkg::AreaW;

  logic [DimW-1:0]          width_q, height_q;
  logic [bct_pkg::PixW-1:0] thr_q;
  logic [bct_pkg::CntW-1:0] min_q;
  logic [DimW-1:0]          w_use, h_use;
  bct_pkg::cfg_t            cfg;
  bct_pkg::res_t            res;
  logic                     slot_free;

  logic                       out_valid_q;
  logic                       found_q, done_q, ovf_q;
  logic [bct_pkg::CntW-1:0]   count_q;
  logic [bct_pkg::PixAw-1:0]  index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(bct_pkg::MaxWidth);
      height_q <= DimW'(bct_pkg::MaxHeight);
      thr_q    <= 8'd128;
      min_q    <= '0;
    end else if (cfg_we_i) begin
      case (bct_pkg::reg_e'(cfg_index_i))
        bct_pkg::REG_WIDTH:      width_q  <= cfg_wdata_i[DimW-1:0];
        bct_pkg::REG_HEIGHT:     height_q <= cfg_wdata_i[DimW-1:0];
        bct_pkg::REG_THRESHOLD:  thr_q    <= cfg_wdata_i[bct_pkg::PixW-1:0];
        bct_pkg::REG_MIN_REGION: min_q    <= cfg_wdata_i;
        default:                 min_q    <= min_q;
      endcase
    end
  end

  // dimensions in use are clamped to the supported range
  always_comb begin
    if (width_q < DimW'(3)) begin
      w_use = DimW'(3);
    end else if (width_q > DimW'(bct_pkg::MaxWidth)) begin
      w_use = DimW'(bct_pkg::MaxWidth);
    end else begin
      w_use = width_q;
    end
    if (height_q < DimW'(3)) begin
      h_use = DimW'(3);
    end else if (height_q > DimW'(bct_pkg::MaxHeight)) begin
      h_use = DimW'(bct_pkg::MaxHeight);
    end else begin
      h_use = height_q;
    end
    cfg.width      = w_use;
    cfg.height     = h_use;
    cfg.area       = AreaW'(w_use) * AreaW'(h_use);
    cfg.last_row   = AreaW'(w_use) * (AreaW'(h_use) - AreaW'(1));
    cfg.threshold  = thr_q;
    cfg.min_region = min_q;
  end

  assign slot_free = !out_valid_q || out_ready_i;

  bct_engine u_engine (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_op_i    (bct_pkg::op_e'(operation_i)),
    .req_addr_i  (address_i),
    .req_pixel_i (pixel_i),
    .slot_free_i (slot_free),
    .res_o       (res)
  );

  // output register: holds the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      index_q     <= '0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
      found_q     <= res.found;
      done_q      <= res.scan_done;
      ovf_q       <= res.overflow;
      count_q     <= res.point_count;
      index_q     <= res.point_index;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign scan_done_o   = done_q;
  assign point_count_o = count_q;
  assign point_index_o = index_q;
  assign overflow_o    = ovf_q;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for binary_contour_tracer_top: directed table, then phased random traffic
// carries its own tracer predictor; depends on bct_pkg for the op and register codes
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic        found;
    logic        done;
    logic [12:0] count;
    logic [15:0] index;
    logic        ovf;
  } beat_t;

  typedef struct packed {
    bct_pkg::op_e op;
    logic [15:0]  addr;
    logic [7:0]   pix;
    logic         typed;
    beat_t        want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [15:0] address_i = '0;
  logic [7:0]  pixel_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o, scan_done_o, overflow_o;
  logic [12:0] point_count_o;
  logic [15:0] point_index_o;

  binary_contour_tracer_top u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("binary_contour_tracer_top verification failed");
    $finish;
  end

  // tracer shadow state
  logic [7:0]  img [65536];
  bit          seen [65536];
  logic [15:0] pts [4096];
  int          reg_w = 256, reg_h = 256, reg_thr = 128, reg_min = 0;
  int          scan_pos = 0, stored = 0, trail = 0;
  bit          ovf_flag = 0;

  beat_t exp_beats [$];
  int    mismatches = 0;
  bit    steady = 0;
  int    long_hold = 0;

  function automatic int eff_w();
    return reg_w < 3 ? 3 : (reg_w > bct_pkg::MaxWidth ? bct_pkg::MaxWidth : reg_w);
  endfunction

  function automatic int eff_h();
    return reg_h < 3 ? 3 : (reg_h > bct_pkg::MaxHeight ? bct_pkg::MaxHeight : reg_h);
  endfunction

  function automatic bit fg(longint idx, longint area);
    if (idx < 0 || idx >= area) return 0;
    return img[idx] < reg_thr;
  endfunction

  function automatic void add_point(longint idx);
    if (trail < bct_pkg::MaxPoints) pts[trail] = idx[15:0];
    else ovf_flag = 1;
    trail++;
  endfunction

  function automatic void follow_outline(longint start, longint w, longint area);
    longint dg [4];
    longint st [4];
    longint i;
    longint steps;
    longint lim;
    int     d;
    dg = '{-1 - w, 1 - w, 1 + w, -1 + w};
    st = '{-w, 1, w, -1};
    i = start;
    d = 0;
    steps = 0;
    lim = 4 * area + 4;
    trail = 0;
    ovf_flag = 0;
    add_point(start);
    if (!fg(i + dg[0], area) && !fg(i + st[0], area)) begin
      d = 1;
      if (!fg(i + dg[1], area) && !fg(i + st[1], area)) begin
        d = 2;
        if (!fg(i + dg[2], area) && !fg(i + st[2], area)) d = 3;
      end
    end
    do begin
      if (fg(i + dg[d], area)) begin
        i += dg[d];
        add_point(i);
        d = (d + 3) & 3;
      end else if (fg(i + st[d], area)) begin
        i += st[d];
        add_point(i);
      end else begin
        d = (d + 1) & 3;
      end
      seen[i] = 1;
      steps++;
    end while (i != start && steps < lim);
    stored = trail < bct_pkg::MaxPoints ? trail : bct_pkg::MaxPoints;
  endfunction

  function automatic beat_t predict_beat(bct_pkg::op_e op, int addr, logic [7:0] pix);
    beat_t b;
    int    w, h, area, stop, i;
    bit    bg, c;
    w = eff_w();
    h = eff_h();
    area = w * h;
    b = '0;
    case (op)
      bct_pkg::OP_WRITE: begin
        if (addr < area) img[addr] = pix;
      end
      bct_pkg::OP_BEGIN: begin
        for (int k = 0; k < w; k++) begin
          img[k] = 8'd255;
          img[area - 1 - k] = 8'd255;
        end
        for (int k = 0; k < h; k++) begin
          img[k * w] = 8'd255;
          img[k * w + w - 1] = 8'd255;
        end
        foreach (seen[k]) seen[k] = 0;
        scan_pos = w + 1;
      end
      bct_pkg::OP_FIND: begin
        stop = w * (h - 1);
        bg = !fg(scan_pos, area);
        for (i = scan_pos; i < stop; i++) begin
          c = fg(i, area);
          if (bg && c && !seen[i]) begin
            seen[i] = 1;
            follow_outline(i, w, area);
            if (trail > reg_min) begin
              scan_pos = i;
              b.found = 1;
              break;
            end
          end
          bg = !c;
        end
        if (!b.found) begin
          scan_pos = stop;
          b.done = 1;
        end
      end
      default: begin
        if (addr < stored && addr < bct_pkg::MaxPoints) b.index = pts[addr];
      end
    endcase
    b.count = stored[12:0];
    b.ovf = ovf_flag;
    return b;
  endfunction

  // one input beat; the predictor runs at acceptance
  task automatic send(bct_pkg::op_e op, int addr, logic [7:0] pix, bit typed = 0,
                      beat_t want = '0);
    beat_t b;
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    address_i   <= addr[15:0];
    pixel_i     <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    b = predict_beat(op, addr, pix);
    exp_beats = {exp_beats, (typed ? want : b)};
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (exp_beats.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(bct_pkg::reg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[12:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bct_pkg::REG_WIDTH:     reg_w = val & 'h1ff;
      bct_pkg::REG_HEIGHT:    reg_h = val & 'h1ff;
      bct_pkg::REG_THRESHOLD: reg_thr = val & 'hff;
      default:                reg_min = val & 'h1fff;
    endcase
  endtask

  function automatic logic [7:0] pick_pix(int dens);
    if (reg_thr > 0 && $urandom_range(0, 99) < dens) return 8'($urandom_range(0, reg_thr - 1));
    return 8'($urandom_range(reg_thr, 255));
  endfunction

  // receiver side: random stall bursts, a long hold on request, none at the end
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      out_ready_i <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{found_o, scan_done_o, point_count_o, point_index_o, overflow_o};
      if (exp_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = exp_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  row_t rows [$];
  int   ph_w   [7] = '{3, 0, 16, 8, 511, 12, 10};
  int   ph_h   [7] = '{3, 1, 12, 8, 3, 10, 7};
  int   ph_thr [7] = '{128, 255, 128, 0, 200, 100, 129};
  int   ph_min [7] = '{0, 1, 2, 4096, 8191, 4, 3};
  int   ph_den [7] = '{50, 50, 40, 50, 45, 60, 50};
  int   ph_ops [7] = '{100, 80, 150, 80, 40, 100, 90};

  initial begin
    int area, r, a, extra_begins;
    logic [7:0] v;
    extra_begins = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // straight after reset: nothing traced, every field reads zero
    rows = '{
      '{bct_pkg::OP_READ,  16'd0,     8'd0,   1'b1, '0},
      '{bct_pkg::OP_READ,  16'hffff,  8'd0,   1'b1, '0},
      '{bct_pkg::OP_WRITE, 16'hffff,  8'hff,  1'b1, '0},
      '{bct_pkg::OP_WRITE, 16'd0,     8'd0,   1'b1, '0},
      '{bct_pkg::OP_READ,  16'd4095,  8'd0,   1'b1, '0}
    };
    foreach (rows[k]) send(rows[k].op, rows[k].addr, rows[k].pix, rows[k].typed, rows[k].want);
    settle();
    write_reg(bct_pkg::REG_WIDTH, 4);
    write_reg(bct_pkg::REG_HEIGHT, 4);
    write_reg(bct_pkg::REG_THRESHOLD, 128);
    write_reg(bct_pkg::REG_MIN_REGION, 0);
    // 4x4: diagonal pair in the interior, writes outside the image, reads past count
    rows = '{
      '{bct_pkg::OP_WRITE, 16'd5,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_WRITE, 16'd6,     8'd255, 1'b0, '0},
      '{bct_pkg::OP_WRITE, 16'd9,     8'd200, 1'b0, '0},
      '{bct_pkg::OP_WRITE, 16'd10,    8'd127, 1'b0, '0},
      '{bct_pkg::OP_WRITE, 16'd16,    8'd0,   1'b1, '0},
      '{bct_pkg::OP_WRITE, 16'hffff,  8'd0,   1'b1, '0},
      '{bct_pkg::OP_BEGIN, 16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_FIND,  16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_READ,  16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_READ,  16'd1,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_READ,  16'd4096,  8'd0,   1'b0, '0},
      '{bct_pkg::OP_FIND,  16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_FIND,  16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_FIND,  16'd0,     8'd0,   1'b0, '0},
      '{bct_pkg::OP_READ,  16'hffff,  8'd0,   1'b0, '0}
    };
    foreach (rows[k]) send(rows[k].op, rows[k].addr, rows[k].pix, rows[k].typed, rows[k].want);

    for (int p = 0; p < 7; p++) begin
      settle();
      if (p == 6) steady = 1;
      write_reg(bct_pkg::REG_WIDTH, ph_w[p]);
      write_reg(bct_pkg::REG_HEIGHT, ph_h[p]);
      write_reg(bct_pkg::REG_THRESHOLD, ph_thr[p]);
      write_reg(bct_pkg::REG_MIN_REGION, ph_min[p]);
      area = eff_w() * eff_h();
      if (p == 2) long_hold = 400;
      for (a = 0; a < area; a++) begin
        v = pick_pix(ph_den[p]);
        send(bct_pkg::OP_WRITE, a, v);
      end
      send(bct_pkg::OP_BEGIN, 0, 8'd0);
      if (p == 5) begin
        // sender waits for every outstanding result before going on
        settle();
      end
      for (int n = 0; n < ph_ops[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, area - 1);
          v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_pix(50);
          send(bct_pkg::OP_WRITE, a, v);
        end else if (r < 64) begin
          send(bct_pkg::OP_FIND, $urandom_range(0, 65535), 8'($urandom_range(0, 255)));
        end else if (r == 99 && extra_begins < 3 && area < 400) begin
          extra_begins++;
          send(bct_pkg::OP_BEGIN, $urandom_range(0, 65535), 8'($urandom_range(0, 255)));
        end else begin
          a = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, stored + 2);
          send(bct_pkg::OP_READ, a, 8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && exp_beats.size() == 0)
      $display("binary_contour_tracer_top verification clean");
    else
      $display("binary_contour_tracer_top verification failed");
    $finish;
  end

endmodule
